// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the list block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hdl/iida_pkg.sv -----
// Package for the indexed insert/delete list: widths, codes, and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package iida_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int POS_W        = 7;
  localparam int VAL_W        = 32;
  localparam int COUNT_W      = 7;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Work the datapath does at an edge.
  typedef enum logic [2:0] {
    OP_IDLE,    // no item this cycle
    OP_NOP,     // item taken, list unchanged, read value zero
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/iida_cmd_if.sv -----
// Command channel: valid/ready handshake with command, position, new_value.
// Depends on iida_pkg.
`default_nettype none

interface iida_cmd_if;
  import iida_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] new_value;

  modport source (output valid, command, position, new_value, input ready);
  modport sink   (input valid, command, position, new_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/iida_res_if.sv -----
// Result channel: valid/ready handshake with status, read_value, entry_count.
// Depends on iida_pkg.
`default_nettype none

interface iida_res_if;
  import iida_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] read_value;
  logic [COUNT_W-1:0]      entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/iida_ctrl.sv -----
// Controller: handshake, command decode and range checks, status register.
// Depends on iida_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module iida_ctrl #(
  parameter int CAPACITY = iida_pkg::DEF_CAPACITY
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cmd_valid,
  output logic                         cmd_ready,
  input  wire  [iida_pkg::CMD_W-1:0]   command,
  input  wire  [iida_pkg::POS_W-1:0]   position,
  output logic                         res_valid,
  input  wire                          res_ready,
  output logic [iida_pkg::STATUS_W-1:0] status,
  output iida_pkg::dp_cmd_t            dp_cmd,
  input  iida_pkg::dp_stat_t           dp_stat
);
  import iida_pkg::*;

  typedef enum logic {S_IDLE, S_HOLD} state_t;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

  state_t  state;
  status_t status_reg;
  status_t status_next;
  logic    accept;

  // no item is taken while reset is held
  assign cmd_ready = !rst && ((state == S_IDLE) || res_ready);
  assign accept    = cmd_valid && cmd_ready;
  assign res_valid = (state == S_HOLD);
  assign status    = status_reg;

  always_comb begin
    status_next = ST_DONE;
    dp_cmd.op   = OP_IDLE;
    if (accept) begin
      dp_cmd.op = OP_NOP;
      unique case (cmd_code_t'(command))
        CMD_INSERT: begin
          priority if (dp_stat.count >= CAP) begin
            status_next = ST_FULL;
          end else if (position > dp_stat.count) begin
            status_next = ST_BAD_INDEX;
          end else begin
            dp_cmd.op = OP_INSERT;
          end
        end
        CMD_DELETE: begin
          if (position >= dp_stat.count) begin
            status_next = ST_BAD_INDEX;
          end else begin
            dp_cmd.op = OP_DELETE;
          end
        end
        CMD_READ: begin
          if (position >= dp_stat.count) begin
            status_next = ST_BAD_INDEX;
          end else begin
            dp_cmd.op = OP_READ;
          end
        end
        default: begin
          // unused code: accepted, no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_HOLD;
        S_HOLD: if (!accept && res_ready) state <= S_IDLE;
      endcase
    end
    if (accept) status_reg <= status_next;
  end

  `ASSERT_NEVER(a_count_cap, clk, rst, dp_stat.count > CAP, "count above capacity")
  `ASSERT_CLK(a_ins_count, clk, rst,
    (dp_cmd.op == OP_INSERT) |=> (dp_stat.count == $past(dp_stat.count) + 7'd1),
    "insert did not bump count")
  `ASSERT_CLK(a_del_count, clk, rst,
    (dp_cmd.op == OP_DELETE) |=> (dp_stat.count == $past(dp_stat.count) - 7'd1),
    "delete did not drop count")
  `ASSERT_CLK(a_full_stat, clk, rst,
    (res_valid && status_reg == ST_FULL) |-> (dp_stat.count == CAP),
    "full status with room left")

endmodule

`default_nettype wire

// ----- hdl/iida_dp.sv -----
// Datapath: row of shift cells, entry count, and the read result register.
// Depends on iida_pkg.
`default_nettype none

module iida_dp #(
  parameter int CAPACITY = iida_pkg::DEF_CAPACITY
) (
  input  wire                                clk,
  input  wire                                rst,
  input  iida_pkg::dp_cmd_t                  dp_cmd,
  output iida_pkg::dp_stat_t                 dp_stat,
  input  wire  [iida_pkg::POS_W-1:0]         position,
  input  wire  signed [iida_pkg::VAL_W-1:0]  new_value,
  output logic signed [iida_pkg::VAL_W-1:0]  read_value,
  output logic [iida_pkg::COUNT_W-1:0]       entry_count
);
  import iida_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic [COUNT_W-1:0]      count;
  logic signed [VAL_W-1:0] rd_reg;

  assign dp_stat.count = count;
  assign entry_count   = count;
  assign read_value    = rd_reg;

  // Each cell holds, loads the new value, or takes a neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (dp_cmd.op == OP_INSERT) begin
        if (COUNT_W'(i) == position) begin
          cells[i] <= new_value;
        end else if (COUNT_W'(i) > position) begin
          if (i > 0) cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end else if (dp_cmd.op == OP_DELETE) begin
        if (COUNT_W'(i) >= position && i < CAPACITY - 1) begin
          cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (dp_cmd.op)
        OP_INSERT: count <= count + 7'd1;
        OP_DELETE: count <= count - 7'd1;
        default:   count <= count;
      endcase
    end
    if (dp_cmd.op != OP_IDLE) begin
      rd_reg <= (dp_cmd.op == OP_READ) ? cells[position[IDX_W-1:0]] : '0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/indexed_insert_delete_array.sv -----
// Top level of the indexed insert/delete list: controller plus datapath.
// Depends on iida_pkg, iida_cmd_if, iida_res_if, iida_ctrl, iida_dp.
//
// Keeps a packed list of up to CAPACITY signed 32-bit entries. Each command
// item (insert at 0..count, delete at 0..count-1, read at 0..count-1) gives
// one result item with a status (done, full, invalid index), the value read
// (zero unless a successful read) and the entry count after the command.
// Insert into a full list reports full before any index check; code 3 is a
// no-op with status done. Every command is finished in the cycle it is
// accepted: the entries sit in a row of cells, each of which holds, loads
// the new value, or takes its left or right neighbor, so one item per cycle
// is sustained while results are taken. The result sits in an output
// register; a new item is taken in the same cycle the waiting result leaves,
// so ready drops only while a held result is not taken. Result valid rises
// in the cycle after accept. The list is empty after reset; no clearing pass.
`default_nettype none

module indexed_insert_delete_array #(
  parameter int CAPACITY = iida_pkg::DEF_CAPACITY
) (
  input wire          clk,
  input wire          rst,
  iida_cmd_if.sink    cmd,
  iida_res_if.source  res
);
  import iida_pkg::*;

  dp_cmd_t  dp_cmd;   // controller -> datapath
  dp_stat_t dp_stat;  // datapath -> controller

  iida_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .command   (cmd.command),
    .position  (cmd.position),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .status    (res.status),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  iida_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .position    (cmd.position),
    .new_value   (cmd.new_value),
    .read_value  (res.read_value),
    .entry_count (res.entry_count)
  );

endmodule

`default_nettype wire

// ----- dv/indexed_insert_delete_array_test.sv -----
`timescale 1ns / 100ps
// Testbench for indexed_insert_delete_array: a directed table, then a random
// command mix, every result checked against an in-bench list predictor.
// Depends on iida_pkg, iida_cmd_if, iida_res_if and the block's RTL.

module indexed_insert_delete_array_test;
  import iida_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1250;
  // Long receiver hold-off; more than enough to fill the output register
  // and stall the command side.
  localparam int HOLD_CYCLES  = 200;
  // Cycles with no item moving on either side before the run is called hung.
  localparam int QUIET_LIMIT  = 2000;
  // Cycles waited after the last expected result to catch any stray one.
  localparam int DRAIN_CYCLES = 8;
  // Code 3 has no enum member; the block treats it as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      entry_count;
  } list_result_t;

  // One directed command; result is typed in only where it is obvious.
  typedef struct {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    bit                      typed;
    list_result_t            result;
  } directed_row_t;

  typedef enum {PH_GROW, PH_MIXED, PH_SHRINK} load_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  iida_cmd_if cmd_ch ();
  iida_res_if res_ch ();

  indexed_insert_delete_array i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Predictor state: the list contents and how many entries are in use.
  logic signed [VAL_W-1:0] list_entries [CAPACITY];
  int unsigned             list_count = 0;

  // Results still owed by the block, oldest first.
  list_result_t pending_results [$];

  int error_count   = 0;
  bit steady_phase  = 1'b0;   // both sides keep valid/ready high
  int hold_requests = 0;      // bumped by the sender side to ask for a hold-off
  int hold_taken    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Apply one command to the predictor's list and return what the block
  // must answer. Full is checked before the index on insert.
  function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  i;
    r.status     = ST_DONE;
    r.read_value = '0;
    case (cmd)
      CMD_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = list_count; i > pos; i--) list_entries[i] = list_entries[i-1];
          list_entries[pos] = val;
          list_count++;
        end
      end
      CMD_DELETE: begin
        if (pos >= list_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = pos; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          list_count--;
        end
      end
      CMD_READ: begin
        if (pos >= list_count) r.status = ST_BAD_INDEX;
        else r.read_value = list_entries[pos];
      end
      default: ;  // unused code: no change, status done
    endcase
    r.entry_count = COUNT_W'(list_count);
    return r;
  endfunction

  function automatic directed_row_t dir_row(input logic [CMD_W-1:0] cmd,
                                            input logic [POS_W-1:0] pos,
                                            input logic signed [VAL_W-1:0] val,
                                            input bit typed,
                                            input logic [STATUS_W-1:0] st,
                                            input logic signed [VAL_W-1:0] rd,
                                            input logic [COUNT_W-1:0] cnt);
    directed_row_t row;
    row.command            = cmd;
    row.position           = pos;
    row.new_value          = val;
    row.typed              = typed;
    row.result.status      = st;
    row.result.read_value  = rd;
    row.result.entry_count = cnt;
    return row;
  endfunction

  // Offer one command, with random idle cycles in front of it, and hold it
  // until accepted. The predictor runs at the accepting edge, so the queue
  // stays in command order. valid is left high so back-to-back items keep
  // it asserted without a second assignment in one step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val, input bit typed,
                           input list_result_t typed_result);
    list_result_t predicted;
    while (!steady_phase && $urandom_range(0, 99) < 8) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= cmd;
    cmd_ch.position  <= pos;
    cmd_ch.new_value <= val;
    do begin
      @(posedge clk);
    end while (!cmd_ch.ready);
    predicted = apply_command(cmd, pos, val);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Compare the result on the channel with the oldest expectation.
  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with nothing expected: status %0d read_value %0d count %0d",
             res_ch.status, res_ch.read_value, res_ch.entry_count);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (res_ch.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, res_ch.status);
        error_count++;
      end
      if (res_ch.read_value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, res_ch.read_value);
        error_count++;
      end
      if (res_ch.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count,
               res_ch.entry_count);
        error_count++;
      end
    end
  endtask

  // Result side: check what is taken, then pick ready for the next edge.
  // A hold-off request drops ready while hold_left counts down from HOLD_CYCLES.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_result();
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_taken   <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady_phase || ($urandom_range(0, 99) >= 8);
    end
  end

  // Watchdog: too long with no item moving on either channel means a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("indexed_insert_delete_array test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    directed_row_t           directed_rows [$];
    list_result_t            no_result;
    load_phase_t             phase;
    int                      phase_left;
    int                      phase_num;
    int                      n;
    int                      r;
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;

    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_INSERT;
    cmd_ch.position  = '0;
    cmd_ch.new_value = '0;
    res_ch.ready     = 1'b0;
    no_result        = '{status: '0, read_value: '0, entry_count: '0};

    // Directed table. Empty list first: every access is out of range.
    directed_rows.push_back(dir_row(CMD_READ,   7'd0,   32'sd0, 1, ST_BAD_INDEX, 32'sd0, 7'd0));
    directed_rows.push_back(dir_row(CMD_DELETE, 7'd0,   32'sd0, 1, ST_BAD_INDEX, 32'sd0, 7'd0));
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd1,   32'sd5, 1, ST_BAD_INDEX, 32'sd0, 7'd0));
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd127, 32'sd5, 1, ST_BAD_INDEX, 32'sd0, 7'd0));
    // Value extremes, insert at the head pushes the older entry up.
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd0, 32'sh7fffffff, 1, ST_DONE, 32'sd0, 7'd1));
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd0, 32'sh80000000, 1, ST_DONE, 32'sd0, 7'd2));
    directed_rows.push_back(dir_row(CMD_READ, 7'd0, 32'sd0, 1, ST_DONE, 32'sh80000000, 7'd2));
    directed_rows.push_back(dir_row(CMD_READ, 7'd1, 32'sd0, 1, ST_DONE, 32'sh7fffffff, 7'd2));
    directed_rows.push_back(dir_row(CMD_READ, 7'd2, 32'sd0, 1, ST_BAD_INDEX, 32'sd0, 7'd2));
    // Append at index == count.
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd2, -32'sd1, 1, ST_DONE, 32'sd0, 7'd3));
    // Unused code does nothing, whatever the position.
    directed_rows.push_back(dir_row(CMD_UNUSED, 7'd0,   32'sd1234, 1, ST_DONE, 32'sd0, 7'd3));
    directed_rows.push_back(dir_row(CMD_UNUSED, 7'd127, -32'sd1,   1, ST_DONE, 32'sd0, 7'd3));
    directed_rows.push_back(dir_row(CMD_READ,   7'd127, 32'sd0, 1, ST_BAD_INDEX, 32'sd0, 7'd3));
    directed_rows.push_back(dir_row(CMD_DELETE, 7'd3,   32'sd0, 1, ST_BAD_INDEX, 32'sd0, 7'd3));
    directed_rows.push_back(dir_row(CMD_DELETE, 7'd127, 32'sd0, 1, ST_BAD_INDEX, 32'sd0, 7'd3));
    // Middle insert and deletes at head and tail: shifting, predictor-checked.
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd1, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_READ,   7'd1, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_READ,   7'd2, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_DELETE, 7'd0, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_READ,   7'd0, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_DELETE, 7'd2, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_READ,   7'd1, 32'sd0, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd2, 32'sh55555555, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_INSERT, 7'd0, 32'shaaaaaaaa, 0, '0, '0, '0));
    directed_rows.push_back(dir_row(CMD_READ,   7'd3, 32'sd0, 0, '0, '0, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_item(directed_rows[k].command, directed_rows[k].position,
                directed_rows[k].new_value, directed_rows[k].typed,
                directed_rows[k].result);

    // Random part. Phases bias the mix so the list fills up to capacity
    // (and inserts into a full list get tried), drains to empty, and
    // wanders in between. Most positions are legal; the rest are noise
    // across the whole 7-bit range.
    phase      = PH_GROW;
    phase_left = 150;
    phase_num  = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_num++;
        case (phase_num % 4)
          0:       phase = PH_GROW;
          2:       phase = PH_SHRINK;
          default: phase = PH_MIXED;
        endcase
        phase_left = $urandom_range(80, 150);
      end
      phase_left--;

      // Pressure: a long receiver hold-off while commands keep coming,
      // a full drain with the sender paused, and a stretch with no idling.
      if (n == 300) hold_requests <= hold_requests + 1;
      if (n == 700) begin
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      steady_phase <= (n >= 900 && n < 1100);

      r = $urandom_range(0, 99);
      case (phase)
        PH_GROW:   cmd = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_READ :
                         (r < 97) ? CMD_DELETE : CMD_UNUSED;
        PH_SHRINK: cmd = (r < 65) ? CMD_DELETE : (r < 85) ? CMD_READ :
                         (r < 97) ? CMD_INSERT : CMD_UNUSED;
        default:   cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_DELETE :
                         (r < 97) ? CMD_READ : CMD_UNUSED;
      endcase

      if ($urandom_range(0, 99) < 15 || cmd == CMD_UNUSED)
        pos = POS_W'($urandom_range(0, 127));
      else if (cmd == CMD_INSERT)
        pos = POS_W'($urandom_range(0, list_count));
      else if (list_count > 0)
        pos = POS_W'($urandom_range(0, list_count - 1));
      else
        pos = POS_W'($urandom_range(0, 127));

      case ($urandom_range(0, 19))
        0:       val = 32'sh7fffffff;
        1:       val = 32'sh80000000;
        2:       val = '0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase

      send_item(cmd, pos, val, 1'b0, no_result);
    end
    cmd_ch.valid <= 1'b0;

    // Wait out the last results (watchdog bounds this), then a few more
    // cycles so a stray extra result is caught as unexpected.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("indexed_insert_delete_array test passed");
    end else begin
      $display("indexed_insert_delete_array test failed");
    end
    $finish;
  end

endmodule
